// ----- rtl/ffba_pkg.sv -----
package ffba_pkg;

    localparam int ADDR_W          = 32;
    localparam int SIZE_W          = 25;
    localparam int MAP_W           = 15;
    localparam int NUM_BLOCKS_DEF  = 16384;
    localparam int BLOCK_BYTES_DEF = 1024;

    localparam logic [MAP_W-1:0]  MAP_MAX        = 15'h7fff;
    localparam logic [ADDR_W-1:0] TAKE_BASE_RST  = 32'h02A0_0000;

    // Operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_TAKE  = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE_BASE   = 1'd1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] req_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic              ok;
        logic              outside_region;
    } t_rsp;

    // Clamp a block count to what one map entry holds
    function automatic logic [MAP_W-1:0] sat_count(input logic [ADDR_W-1:0] n);
        return (n > ADDR_W'(MAP_MAX)) ? MAP_MAX : n[MAP_W-1:0];
    endfunction

endpackage

// ----- rtl/ffba_div.sv -----
// Division by the block size: reciprocal multiply, then one correction step.
module ffba_div
    import ffba_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_quotient
);

    // floor((2^32-1)/B) leaves the first estimate at most one below the quotient
    localparam logic [ADDR_W-1:0] RECIP   = ADDR_W'(64'hFFFF_FFFF / 64'(BLOCK_BYTES));
    localparam logic [ADDR_W-1:0] DIVISOR = ADDR_W'(BLOCK_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_FIX
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic [ADDR_W-1:0]   r_num;
    logic [ADDR_W-1:0]   r_quo;
    logic [ADDR_W-1:0]   r_rem;

    logic [2*ADDR_W-1:0] prod;

    assign prod = {{ADDR_W{1'b0}}, r_num} * {{ADDR_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_dividend;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_quo   <= prod[2*ADDR_W-1:ADDR_W];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rem   <= r_num - r_quo * DIVISOR;
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    // Bump the estimate when a whole block is left over
                    if (r_rem >= DIVISOR) begin
                        r_quo <= r_quo + ADDR_W'(1);
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// Channel   Direction  Handshake               Word
// in        input      i_in_valid / o_in_stall  t_req (opcode, size_bytes, req_address)
// out       output     o_out_valid / i_out_stall t_rsp (result_address, ok, outside_region)
// cfg       input      i_cfg_we, i_cfg_idx     i_cfg_data (region_base, take_base)
//
// After reset the map is swept to zero, one entry a cycle; during the sweep
// o_in_stall stays high (configuration writes are taken).
// One word is handled at a time: a no-op or an outside free needs no division,
// a free or an allocate that needs no scan needs one, and a take needs two.
// A scanning allocate also reads the map entry by entry and jumps past each allocation it meets.
// A finished word waits in the output register; the next word is accepted
// while it waits, and the block holds its result until that register frees.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_req                 i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_rsp                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    // Index width, window count width and scan position width. A position can
    // run past the end by at most one saturated map value.
    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int NW = IW + 1;
    localparam int PW = ((IW > MAP_W) ? IW : MAP_W) + 1;

    localparam longint unsigned REGION_BYTES = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
    localparam logic [ADDR_W:0]   REGION_LIM = (ADDR_W+1)'(REGION_BYTES);
    localparam logic [ADDR_W-1:0] NUM_A      = ADDR_W'(NUM_BLOCKS);
    localparam logic [ADDR_W-1:0] ROUND_UP   = ADDR_W'(BLOCK_BYTES - 1);
    localparam logic [ADDR_W-1:0] BB_A       = ADDR_W'(BLOCK_BYTES);
    localparam logic [PW:0]       NUM_P      = (PW+1)'(NUM_BLOCKS);
    localparam logic [IW-1:0]     LAST_IDX   = IW'(NUM_BLOCKS - 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV_IDX,
        S_DIV_NEED,
        S_SCAN,
        S_MUL,
        S_ADD,
        S_FIN
    } t_state;

    t_state            r_state;
    t_req              r_req;
    t_rsp              r_res;
    t_rsp              r_out;
    logic              r_out_vld;
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_take_base;
    logic [ADDR_W-1:0] r_off;
    logic [IW-1:0]     r_idx;
    logic              r_idx_ok;
    logic [IW-1:0]     r_clr;
    logic [NW-1:0]     r_need;
    logic [MAP_W-1:0]  r_sat;
    logic [PW-1:0]     r_i;       // window start
    logic [PW-1:0]     r_rp;      // next read position
    logic [PW-1:0]     r_cp;      // position whose data is on r_rd
    logic [PW-1:0]     r_end;     // one past the window
    logic              r_chk;
    logic [ADDR_W-1:0] r_prod;
    logic              r_div_go;
    logic [ADDR_W-1:0] r_div_arg;

    // Block map: one count per block, nonzero at the first block of an allocation
    logic [MAP_W-1:0]  r_map [NUM_BLOCKS];
    logic [MAP_W-1:0]  r_rd;

    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    logic [MAP_W-1:0]  mem_wd;

    logic              div_done;
    logic [ADDR_W-1:0] div_q;

    logic [ADDR_W-1:0] take_off;
    logic [ADDR_W-1:0] free_off;
    logic              hit;
    logic              clean_last;
    logic [PW-1:0]     jump_i;
    logic              jump_fail;

    ffba_div #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_div_arg),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign take_off = i_in_data.req_address - r_take_base;
    assign free_off = i_in_data.req_address - r_region_base;

    // Scan decisions on the entry that came back from the map this cycle
    assign hit        = r_chk && (r_rd != '0);
    assign clean_last = r_chk && (r_rd == '0) && ((r_cp + PW'(1)) == r_end);
    assign jump_i     = r_cp + PW'(r_rd);
    assign jump_fail  = (({1'b0, jump_i} + (PW+1)'(r_need)) > NUM_P);

    // Map write port: clear sweep, allocation mark, take mark, free
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_SCAN: begin
                if (clean_last) begin
                    mem_we = 1'b1;
                    mem_wa = r_i[IW-1:0];
                    mem_wd = r_sat;
                end
            end
            S_DIV_IDX: begin
                if (div_done && (r_req.opcode == OP_FREE)) begin
                    mem_we = 1'b1;
                    mem_wa = div_q[IW-1:0];
                end
            end
            S_DIV_NEED: begin
                if (div_done && (r_req.opcode == OP_TAKE) && r_idx_ok) begin
                    mem_we = 1'b1;
                    mem_wa = r_idx;
                    mem_wd = sat_count(div_q);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_rd <= r_map[r_rp[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr         <= '0;
            r_out_vld     <= 1'b0;
            r_div_go      <= 1'b0;
            r_chk         <= 1'b0;
            r_region_base <= '0;
            r_take_base   <= TAKE_BASE_RST;
        end else begin
            r_div_go <= 1'b0;

            // Take configuration writes whenever the enable is high
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REGION_BASE: r_region_base <= i_cfg_data;
                    CFG_TAKE_BASE:   r_take_base   <= i_cfg_data;
                    default:         r_take_base   <= r_take_base;
                endcase
            end

            // Drop the output word once taken; a finished word refills it below
            if (r_out_vld && !i_out_stall && (r_state != S_FIN)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        case (i_in_data.opcode)
                            OP_ALLOC: begin
                                r_div_arg <= ADDR_W'(i_in_data.size_bytes) + ROUND_UP;
                                r_div_go  <= 1'b1;
                                r_state   <= S_DIV_NEED;
                            end
                            OP_TAKE: begin
                                r_off     <= take_off;
                                r_div_arg <= take_off;
                                r_div_go  <= 1'b1;
                                r_state   <= S_DIV_IDX;
                            end
                            OP_FREE: begin
                                if ({1'b0, free_off} >= REGION_LIM) begin
                                    r_res   <= '{result_address: '0, ok: 1'b0,
                                                 outside_region: 1'b1};
                                    r_state <= S_FIN;
                                end else begin
                                    r_div_arg <= free_off;
                                    r_div_go  <= 1'b1;
                                    r_state   <= S_DIV_IDX;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end

                S_DIV_IDX: begin
                    if (div_done) begin
                        if (r_req.opcode == OP_FREE) begin
                            r_res   <= '{result_address: '0, ok: 1'b1,
                                         outside_region: 1'b0};
                            r_state <= S_FIN;
                        end else begin
                            r_idx     <= div_q[IW-1:0];
                            r_idx_ok  <= (div_q < NUM_A);
                            r_div_arg <= ADDR_W'(r_req.size_bytes) + ROUND_UP;
                            r_div_go  <= 1'b1;
                            r_state   <= S_DIV_NEED;
                        end
                    end
                end

                S_DIV_NEED: begin
                    if (div_done) begin
                        if (r_req.opcode == OP_TAKE) begin
                            if (r_idx_ok) begin
                                r_res <= '{result_address: r_region_base + r_off,
                                           ok: 1'b1, outside_region: 1'b0};
                            end else begin
                                r_res <= '0;
                            end
                            r_state <= S_FIN;
                        end else if (div_q == '0) begin
                            // Zero-size request: hand out the base, map untouched
                            r_res   <= '{result_address: r_region_base, ok: 1'b1,
                                         outside_region: 1'b0};
                            r_state <= S_FIN;
                        end else if (div_q > NUM_A) begin
                            r_res   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_need  <= div_q[NW-1:0];
                            r_sat   <= sat_count(div_q);
                            r_i     <= '0;
                            r_rp    <= '0;
                            r_end   <= PW'(div_q[NW-1:0]);
                            r_chk   <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (hit) begin
                        // Jump past the allocation; a window past the end fails
                        r_chk <= 1'b0;
                        if (jump_fail) begin
                            r_res   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_i   <= jump_i;
                            r_rp  <= jump_i;
                            r_end <= jump_i + PW'(r_need);
                        end
                    end else if (clean_last) begin
                        r_chk   <= 1'b0;
                        r_state <= S_MUL;
                    end else if (r_rp < r_end) begin
                        r_cp  <= r_rp;
                        r_rp  <= r_rp + PW'(1);
                        r_chk <= 1'b1;
                    end else begin
                        r_chk <= 1'b0;
                    end
                end

                S_MUL: begin
                    r_prod  <= {{(ADDR_W-IW){1'b0}}, r_i[IW-1:0]} * BB_A;
                    r_state <= S_ADD;
                end

                S_ADD: begin
                    r_res   <= '{result_address: r_region_base + r_prod, ok: 1'b1,
                                 outside_region: 1'b0};
                    r_state <= S_FIN;
                end

                S_FIN: begin
                    // Hold until the output register is free
                    if (!r_out_vld || !i_out_stall) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
